FILE: rtl/dmwq_pkg.sv
`timescale 1ns / 1ps

package dmwq_pkg;

  // Width of the capacity register, of the pointers and of the element count.
  localparam int CAP_W = 5;

  // Width of the register index on the configuration port.
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

  localparam logic             MODE_LINEAR   = 1'b0;
  localparam logic             MODE_CIRCULAR = 1'b1;
  localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_NONE  = 3'd2,
    ST_RANGE = 3'd3,
    ST_UNSUP = 3'd4
  } status_t;

  // Capacity in effect: zero counts as one, anything above the store is clipped.
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] raw,
                                               input logic [CAP_W-1:0] cap_max);
    logic [CAP_W-1:0] c;
    c = raw;
    if (raw == '0) begin
      c = CAP_W'(1);
    end else if (raw > cap_max) begin
      c = cap_max;
    end
    return c;
  endfunction

endpackage

FILE: rtl/dual_mode_word_queue.sv
`timescale 1ns / 1ps

// Word queue with a configured capacity and two modes, held in one RAM.
// Requests arrive on the in_valid/in_ready channel (kind, data_word, position);
// each request gives exactly one result on the out_valid/out_ready channel
// (status, read_word, count, full_res, empty_res).
// An enqueue or a request that fails its checks has its result registered at the
// accepting edge. A dequeue or lookup that reads the store passes through the
// read register of the RAM and then the result register; the next request is
// taken once the read is done and the result register is free or being drained.
// A stalled receiver holds the result register, and in_ready stays low until
// the result is taken or taken in the same cycle. After reset the store is
// swept to zero, one entry a cycle, over all DEPTH entries; in_ready stays low
// during the sweep. Reset selects circular mode with a capacity of 16 (clipped
// to DEPTH). Configuration writes (cfg_we, cfg_index, cfg_data) must be made
// only while the queue is idle; the block itself does not enforce this. Any
// write to a known register empties the queue and keeps the store.
module dual_mode_word_queue #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dmwq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmwq_pkg::CAP_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic [WORD_WIDTH-1:0]          data_word,
  input  logic [3:0]                     position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     status,
  output logic [WORD_WIDTH-1:0]          read_word,
  output logic [dmwq_pkg::CAP_W-1:0]     count,
  output logic                           full_res,
  output logic                           empty_res
);

  localparam int CW      = dmwq_pkg::CAP_W;
  localparam int AW      = $clog2(DEPTH);
  localparam int CAP_MAX = (DEPTH < (2 ** CW) - 1) ? DEPTH : (2 ** CW) - 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

  state_t state;

  logic          mode;
  logic [CW-1:0] capacity;
  logic [CW-1:0] front;
  logic [CW-1:0] rear;
  logic [CW-1:0] elem_count;
  logic [AW-1:0] clr_addr;

  dmwq_pkg::status_t out_status;

  logic [CW-1:0] cap;
  logic          accept;

  dmwq_pkg::status_t step_status;
  logic [CW-1:0]     front_next;
  logic [CW-1:0]     rear_next;
  logic [CW-1:0]     count_next;
  logic              step_we;
  logic [CW-1:0]     wr_ptr;
  logic              step_re;
  logic [CW-1:0]     rd_ptr;

  logic          mode_next;
  logic [CW-1:0] capacity_next;
  logic          cfg_hit;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [WORD_WIDTH-1:0] ram_rdata;

  assign cap      = dmwq_pkg::eff_cap(capacity, CW'(CAP_MAX));
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign status   = out_status;

  // Request decode. Pointer updates never depend on the word read, so the
  // whole state moves at the accepting edge.
  always_comb begin
    step_status = dmwq_pkg::ST_OK;
    front_next  = front;
    rear_next   = rear;
    count_next  = elem_count;
    step_we     = 1'b0;
    wr_ptr      = rear;
    step_re     = 1'b0;
    rd_ptr      = front;
    case (kind)
      dmwq_pkg::KIND_ENQUEUE: begin
        if (elem_count >= cap) begin
          step_status = dmwq_pkg::ST_FULL;
        end else if (mode == dmwq_pkg::MODE_LINEAR) begin
          step_we    = 1'b1;
          wr_ptr     = rear;
          rear_next  = rear + CW'(1);
          count_next = elem_count + CW'(1);
        end else begin
          rear_next  = (rear + CW'(1) == cap) ? '0 : rear + CW'(1);
          step_we    = 1'b1;
          wr_ptr     = rear_next;
          count_next = elem_count + CW'(1);
        end
      end
      dmwq_pkg::KIND_DEQUEUE: begin
        if (mode == dmwq_pkg::MODE_LINEAR) begin
          if (front == cap) begin
            // A drained linear queue starts over on the next dequeue.
            front_next  = '0;
            rear_next   = '0;
            count_next  = '0;
            step_status = dmwq_pkg::ST_NONE;
          end else if (front >= rear) begin
            step_status = dmwq_pkg::ST_NONE;
          end else begin
            step_re    = 1'b1;
            rd_ptr     = front;
            front_next = front + CW'(1);
          end
        end else begin
          if (elem_count == '0) begin
            step_status = dmwq_pkg::ST_NONE;
          end else begin
            step_re    = 1'b1;
            rd_ptr     = front;
            front_next = (front + CW'(1) == cap) ? '0 : front + CW'(1);
            count_next = elem_count - CW'(1);
          end
        end
      end
      dmwq_pkg::KIND_LOOKUP: begin
        if (mode != dmwq_pkg::MODE_LINEAR) begin
          step_status = dmwq_pkg::ST_UNSUP;
        end else if (elem_count == '0) begin
          step_status = dmwq_pkg::ST_NONE;
        end else if (CW'(position) >= cap) begin
          step_status = dmwq_pkg::ST_RANGE;
        end else begin
          step_re = 1'b1;
          rd_ptr  = CW'(position);
        end
      end
      default: begin
        step_status = dmwq_pkg::ST_UNSUP;
      end
    endcase
  end

  always_comb begin
    mode_next     = mode;
    capacity_next = capacity;
    cfg_hit       = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        dmwq_pkg::CFG_MODE: begin
          mode_next = cfg_data[0];
          cfg_hit   = 1'b1;
        end
        dmwq_pkg::CFG_CAPACITY: begin
          capacity_next = cfg_data;
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = accept && step_we;
      ram_waddr = AW'(wr_ptr);
      ram_wdata = data_word;
    end
    ram_re = accept && step_re;
  end

  dmwq_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(AW'(rd_ptr)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      mode       <= dmwq_pkg::MODE_CIRCULAR;
      capacity   <= dmwq_pkg::CAP_RESET;
      front      <= '0;
      rear       <= dmwq_pkg::eff_cap(dmwq_pkg::CAP_RESET, CW'(CAP_MAX)) - CW'(1);
      elem_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            out_status <= step_status;
            read_word  <= '0;
            count      <= count_next;
            full_res   <= (count_next >= cap);
            empty_res  <= (count_next == '0);
            out_valid  <= !step_re;
            state      <= step_re ? S_READ : S_IDLE;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          // The result fields were loaded at accept; only the word was pending.
          read_word <= ram_rdata;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_hit) begin
        mode       <= mode_next;
        capacity   <= capacity_next;
        front      <= '0;
        elem_count <= '0;
        rear       <= (mode_next == dmwq_pkg::MODE_CIRCULAR)
                      ? dmwq_pkg::eff_cap(capacity_next, CW'(CAP_MAX)) - CW'(1)
                      : '0;
      end else if (accept) begin
        front      <= front_next;
        rear       <= rear_next;
        elem_count <= count_next;
      end
    end
  end

endmodule

FILE: rtl/dmwq_ram.sv
`timescale 1ns / 1ps

module dmwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/sv/tb_dual_mode_word_queue.sv
`timescale 1ns / 1ps

module tb_dual_mode_word_queue;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 300;

  // Codes the package leaves unnamed: the spare request kind and a register
  // index that selects nothing.
  localparam logic [1:0]                     KIND_RESERVED = 2'd3;
  localparam logic [dmwq_pkg::CFG_IDX_W-1:0] CFG_UNUSED    = 2'd2;

  typedef struct {
    logic [1:0]        kind;
    logic [WORD_W-1:0] word;
    logic [3:0]        pos;
  } qreq_t;

  typedef struct {
    dmwq_pkg::status_t          st;
    logic [WORD_W-1:0]          word;
    logic [dmwq_pkg::CAP_W-1:0] cnt;
    logic                       full;
    logic                       empty;
  } qresp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [dmwq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dmwq_pkg::CAP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [WORD_W-1:0] data_word = '0;
  logic [3:0] position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [WORD_W-1:0] read_word;
  logic [dmwq_pkg::CAP_W-1:0] count;
  logic full_res;
  logic empty_res;

  dual_mode_word_queue #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(WORD_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .data_word(data_word),
    .position(position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .read_word(read_word),
    .count(count),
    .full_res(full_res),
    .empty_res(empty_res)
  );

  always #1 clk = ~clk;

  // Shadow copy of the queue state and its configuration.
  logic                       q_mode;
  logic [dmwq_pkg::CAP_W-1:0] q_cap_raw;
  logic [WORD_W-1:0]          q_store [DEPTH];
  logic [dmwq_pkg::CAP_W-1:0] q_front;
  logic [dmwq_pkg::CAP_W-1:0] q_rear;
  logic [dmwq_pkg::CAP_W-1:0] q_count;

  qreq_t  pending_q[$];
  qresp_t want_q[$];
  int     fail_cnt = 0;
  int     hold_req = 0;

  function automatic logic [dmwq_pkg::CAP_W-1:0] cap_in_use();
    logic [dmwq_pkg::CAP_W-1:0] c;
    c = q_cap_raw;
    if (c == '0) begin
      c = dmwq_pkg::CAP_W'(1);
    end else if (c > DEPTH) begin
      c = dmwq_pkg::CAP_W'(DEPTH);
    end
    return c;
  endfunction

  function automatic void queue_reinit();
    q_front = '0;
    q_count = '0;
    q_rear  = (q_mode == dmwq_pkg::MODE_CIRCULAR) ? cap_in_use() - dmwq_pkg::CAP_W'(1) : '0;
  endfunction

  function automatic void queue_config(logic [dmwq_pkg::CFG_IDX_W-1:0] idx,
                                       logic [dmwq_pkg::CAP_W-1:0] val);
    if (idx == dmwq_pkg::CFG_MODE) begin
      q_mode = val[0];
      queue_reinit();
    end else if (idx == dmwq_pkg::CFG_CAPACITY) begin
      q_cap_raw = val;
      queue_reinit();
    end
  endfunction

  function automatic qresp_t queue_predict(qreq_t r);
    qresp_t                     res;
    logic [dmwq_pkg::CAP_W-1:0] cap;
    logic [WORD_W-1:0]          w;
    cap = cap_in_use();
    res.st = dmwq_pkg::ST_OK;
    w = '0;
    case (r.kind)
      dmwq_pkg::KIND_ENQUEUE: begin
        if (q_count >= cap) begin
          res.st = dmwq_pkg::ST_FULL;
        end else if (q_mode == dmwq_pkg::MODE_LINEAR) begin
          if (q_rear < DEPTH) q_store[q_rear] = r.word;
          q_rear++;
          q_count++;
        end else begin
          q_rear = dmwq_pkg::CAP_W'((int'(q_rear) + 1) % int'(cap));
          q_store[q_rear] = r.word;
          q_count++;
        end
      end
      dmwq_pkg::KIND_DEQUEUE: begin
        if (q_mode == dmwq_pkg::MODE_LINEAR) begin
          if (q_front == cap) begin
            // Drained all the way to capacity: this dequeue rearms the queue.
            q_front = '0;
            q_rear  = '0;
            q_count = '0;
            res.st  = dmwq_pkg::ST_NONE;
          end else if (q_front >= q_rear) begin
            res.st = dmwq_pkg::ST_NONE;
          end else begin
            w = q_store[q_front];
            q_front++;
          end
        end else if (q_count == '0) begin
          res.st = dmwq_pkg::ST_NONE;
        end else begin
          w = q_store[q_front];
          q_front = dmwq_pkg::CAP_W'((int'(q_front) + 1) % int'(cap));
          q_count--;
        end
      end
      dmwq_pkg::KIND_LOOKUP: begin
        if (q_mode != dmwq_pkg::MODE_LINEAR) res.st = dmwq_pkg::ST_UNSUP;
        else if (q_count == '0) res.st = dmwq_pkg::ST_NONE;
        else if (r.pos >= cap) res.st = dmwq_pkg::ST_RANGE;
        else w = q_store[r.pos];
      end
      default: res.st = dmwq_pkg::ST_UNSUP;
    endcase
    res.word  = (res.st == dmwq_pkg::ST_OK) ? w : '0;
    res.cnt   = q_count;
    res.full  = (q_count >= cap);
    res.empty = (q_count == '0);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request driver.
  qreq_t cur_req;
  logic  tx_next;
  int    tx_gap = 0;
  bit    tx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      tx_next = in_valid;
      if (in_valid && in_ready) begin
        want_q.push_back(queue_predict(cur_req));
        tx_next = 1'b0;
        tx_gap = tx_calm ? 0 : pick_gap();
        if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
      end
      if (!tx_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_q.size() != 0) begin
          cur_req = pending_q.pop_front();
          kind      <= cur_req.kind;
          data_word <= cur_req.word;
          position  <= cur_req.pos;
          tx_next = 1'b1;
        end
      end
      in_valid <= tx_next;
    end
  end

  // Result monitor and receiver back-pressure.
  qresp_t w_res;
  logic   rx_next;
  int     rx_stall = 0;
  int     hold_left = 0;
  int     hold_seen = 0;
  bit     rx_calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          fail_cnt++;
          $error("result with no request outstanding");
        end else begin
          w_res = want_q.pop_front();
          if (status !== w_res.st) begin
            fail_cnt++;
            $error("status mismatch: expected %0d, actual %0d", w_res.st, status);
          end
          if (read_word !== w_res.word) begin
            fail_cnt++;
            $error("read_word mismatch: expected %h, actual %h", w_res.word, read_word);
          end
          if (count !== w_res.cnt) begin
            fail_cnt++;
            $error("count mismatch: expected %0d, actual %0d", w_res.cnt, count);
          end
          if (full_res !== w_res.full) begin
            fail_cnt++;
            $error("full_res mismatch: expected %b, actual %b", w_res.full, full_res);
          end
          if (empty_res !== w_res.empty) begin
            fail_cnt++;
            $error("empty_res mismatch: expected %b, actual %b", w_res.empty, empty_res);
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_next = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_next = 1'b0;
      end else begin
        rx_next = 1'b1;
        rx_stall = rx_calm ? 0 : pick_gap();
        if ($urandom_range(0, 99) == 0) rx_calm = !rx_calm;
      end
      out_ready <= rx_next;
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] k, logic [WORD_W-1:0] w, logic [3:0] p);
    qreq_t r;
    r.kind = k;
    r.word = w;
    r.pos  = p;
    pending_q.push_back(r);
  endtask

  // Sampled at the falling edge so that every update of the rising edge has settled.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || want_q.size() != 0 || !in_ready);
  endtask

  task automatic reg_write(logic [dmwq_pkg::CFG_IDX_W-1:0] idx,
                           logic [dmwq_pkg::CAP_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    queue_config(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return WORD_W'($urandom);
  endfunction

  function automatic logic [3:0] rand_pos(int cap);
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, cap - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  // Runs of enqueues and of dequeues with lookups in random order, so that the queue
  // fills, rejects, drains and rearms; a few requests of any kind as noise.
  task automatic random_phase(int n);
    int made;
    int run;
    int sel;
    int cap;
    cap = cap_in_use();
    made = 0;
    while (made < n) begin
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
        run = $urandom_range(1, cap + 2);
        repeat (run) push_req(dmwq_pkg::KIND_ENQUEUE, rand_word(), 4'($urandom));
      end else if (sel < 8) begin
        run = $urandom_range(1, cap + 3);
        repeat (run) begin
          if ($urandom_range(0, 3) != 0) begin
            push_req(dmwq_pkg::KIND_DEQUEUE, rand_word(), 4'($urandom));
          end else begin
            push_req(dmwq_pkg::KIND_LOOKUP, rand_word(), rand_pos(cap));
          end
        end
      end else begin
        run = 1;
        push_req(2'($urandom_range(0, 3)), rand_word(), rand_pos(cap));
      end
      made += run;
    end
  endtask

  initial begin : stim
    logic [dmwq_pkg::CAP_W-1:0] cap_plan [10];
    logic                       mode_pick;
    cap_plan = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd3, 5'd17, 5'd8, 5'd16, 5'd5};

    q_mode    = dmwq_pkg::MODE_CIRCULAR;
    q_cap_raw = dmwq_pkg::CAP_RESET;
    foreach (q_store[i]) q_store[i] = '0;
    queue_reinit();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: circular with the full store.
    push_req(dmwq_pkg::KIND_DEQUEUE, '0, 4'd0);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd0);
    push_req(KIND_RESERVED, '1, 4'd15);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'hFFFF_FFFF, 4'd15);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'h0000_0000, 4'd0);
    repeat (3) push_req(dmwq_pkg::KIND_DEQUEUE, '0, 4'd0);
    wait_quiet();

    // Linear with two slots: fill, reject, range check, drain and rearm.
    reg_write(dmwq_pkg::CFG_MODE, {4'b1111, dmwq_pkg::MODE_LINEAR});
    reg_write(dmwq_pkg::CFG_CAPACITY, 5'd2);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd0);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'hA5A5_5A5A, 4'd0);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'h0123_4567, 4'd0);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'hDEAD_BEEF, 4'd0);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd15);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd1);
    repeat (4) push_req(dmwq_pkg::KIND_DEQUEUE, '0, 4'd0);
    wait_quiet();

    // A capacity of zero behaves as one slot.
    reg_write(dmwq_pkg::CFG_MODE, {4'b0000, dmwq_pkg::MODE_CIRCULAR});
    reg_write(dmwq_pkg::CFG_CAPACITY, 5'd0);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'h8000_0001, 4'd0);
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'h7FFF_FFFE, 4'd0);
    repeat (2) push_req(dmwq_pkg::KIND_DEQUEUE, '0, 4'd0);
    wait_quiet();

    // An oversized capacity is clipped to the store; a write to a spare index
    // changes nothing.
    reg_write(dmwq_pkg::CFG_CAPACITY, 5'd31);
    reg_write(CFG_UNUSED, 5'h1F);
    reg_write(dmwq_pkg::CFG_MODE, {4'b0101, dmwq_pkg::MODE_LINEAR});
    push_req(dmwq_pkg::KIND_ENQUEUE, 32'h5555_AAAA, 4'd0);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd15);
    push_req(dmwq_pkg::KIND_LOOKUP, '0, 4'd0);
    wait_quiet();

    for (int i = 0; i < 10; i++) begin
      mode_pick = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) begin
        reg_write(dmwq_pkg::CFG_MODE, {4'($urandom), mode_pick});
        reg_write(dmwq_pkg::CFG_CAPACITY, cap_plan[i]);
      end else begin
        reg_write(dmwq_pkg::CFG_CAPACITY, cap_plan[i]);
        reg_write(dmwq_pkg::CFG_MODE, {4'($urandom), mode_pick});
      end
      random_phase(170);
      // Keep the receiver off for a long stretch while requests keep coming.
      if (i == 2 || i == 7) hold_req++;
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
